@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/lss_pkg.sv @@
// ----------------------------------------------------------------------------
// lss_pkg
// Opcodes, field widths and shared types of the searchable LIFO stack.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;
  localparam int POS_W   = 6;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_SEARCH = 2'd3
  } opcode_t;

  // Shift commands broadcast to every cell of the stack chain.
  typedef struct packed {
    logic shift_dn;
    logic shift_up;
  } cell_ctrl_t;

endpackage

@@ design/lifo_stack_with_search.sv @@
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Bounded LIFO stack of signed 32-bit words with push, pop, clear and search.
// ----------------------------------------------------------------------------
// The stack is a chain of STACK_DEPTH register cells with the top entry in
// cell 0. A push shifts every cell down by one and loads the new word into
// cell 0; a pop shifts every cell up by one. Push, pop and clear leave the
// sequencer idle, so such items can be accepted on every clock while the
// result side keeps up. A search compares the key against every cell at
// once and then resolves the nearest and the lowest match in a registered
// binary tree of $clog2(STACK_DEPTH) levels; a search item keeps the block
// busy through the launch and wait states until the tree answers, so no
// new item is accepted before its result is loaded. Every item gives
// exactly one result item with the top word (zero when empty), the entry
// count and the empty flag after the operation. A pop on an empty stack or
// a push on a full one changes nothing and raises the underflow or the
// overflow flag. Position fields are zero unless a search found its value.
// There is no configuration and no clearing pass after reset: the fill
// count alone says which cells hold live words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lifo_stack_with_search #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input item channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_opcode,
  input  logic signed [lss_pkg::VALUE_W-1:0]    in_operand_value,
  // Result item channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [lss_pkg::VALUE_W-1:0]    out_top_value,
  output logic [lss_pkg::COUNT_W-1:0]           out_entry_count,
  output logic                                  out_is_empty,
  output logic                                  out_match_found,
  output logic [lss_pkg::POS_W-1:0]             out_pos_from_top,
  output logic [lss_pkg::POS_W-1:0]             out_pos_from_bottom,
  output logic                                  out_overflow_flag,
  output logic                                  out_underflow_flag
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);

  // Control sequencer: idle, a launch state that starts the match tree,
  // then wait for the tree's answer.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LAUNCH = 3'b010,
    ST_WAIT   = 3'b100
  } state_t;

  state_t                               state_r, state_nxt;
  logic [CW-1:0]                        count_r, count_nxt;
  logic signed [lss_pkg::VALUE_W-1:0]   key_r;
  logic                                 out_valid_r, out_valid_nxt;

  logic signed [lss_pkg::VALUE_W-1:0]   out_top_value_r, out_top_value_nxt;
  logic [lss_pkg::COUNT_W-1:0]          out_entry_count_r, out_entry_count_nxt;
  logic                                 out_is_empty_r, out_is_empty_nxt;
  logic                                 out_match_found_r, out_match_found_nxt;
  logic [lss_pkg::POS_W-1:0]            out_pos_top_r, out_pos_top_nxt;
  logic [lss_pkg::POS_W-1:0]            out_pos_bot_r, out_pos_bot_nxt;
  logic                                 out_ovf_r, out_ovf_nxt;
  logic                                 out_unf_r, out_unf_nxt;

  lss_pkg::opcode_t                     op;
  lss_pkg::cell_ctrl_t                  cell_ctrl;
  logic                                 accept;
  logic                                 load;
  logic                                 is_full;
  logic                                 tree_go;
  logic                                 tree_done;
  logic                                 tree_found;
  logic [IW-1:0]                        tree_lo;
  logic [IW-1:0]                        tree_hi;
  logic [STACK_DEPTH-1:0]               cell_match;
  logic [STACK_DEPTH-1:0]               live_hit;
  logic signed [lss_pkg::VALUE_W-1:0]   cell_val [STACK_DEPTH];

  assign op      = lss_pkg::opcode_t'(in_opcode);
  assign is_full = (count_r >= CW'(STACK_DEPTH));

  // A new item may enter only while idle and while the result register is
  // free or being emptied in this very cycle.
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign tree_go  = (state_r == ST_LAUNCH);

  assign cell_ctrl.shift_dn = accept && (op == lss_pkg::OP_PUSH) && !is_full;
  assign cell_ctrl.shift_up = accept && (op == lss_pkg::OP_POP) && (count_r != '0);

  // ---------------------------------------------------------------------------
  // The chain of entry cells. Cell 0 is the top of the stack; the bottom
  // cell keeps its own word on a pop since that word is then no longer live.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic signed [lss_pkg::VALUE_W-1:0] above;
    logic signed [lss_pkg::VALUE_W-1:0] below;

    if (i == 0) begin : g_top
      assign above = in_operand_value;
    end else begin : g_mid_a
      assign above = cell_val[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = cell_val[i];
    end else begin : g_mid_b
      assign below = cell_val[i+1];
    end

    lss_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .from_above (above),
      .from_below (below),
      .key        (key_r),
      .value      (cell_val[i]),
      .match      (cell_match[i])
    );

    // Cells at or beyond the fill count hold stale words and never match.
    assign live_hit[i] = cell_match[i] && (CW'(i) < count_r);
  end

  lss_match_tree #(
    .N  (STACK_DEPTH),
    .IW (IW)
  ) u_tree (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (tree_go),
    .hits  (live_hit),
    .done  (tree_done),
    .found (tree_found),
    .lo    (tree_lo),
    .hi    (tree_hi)
  );

  // ---------------------------------------------------------------------------
  // Next state, fill count and result fields.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt           = state_r;
    count_nxt           = count_r;
    load                = 1'b0;
    out_top_value_nxt   = out_top_value_r;
    out_entry_count_nxt = out_entry_count_r;
    out_is_empty_nxt    = out_is_empty_r;
    out_match_found_nxt = out_match_found_r;
    out_pos_top_nxt     = out_pos_top_r;
    out_pos_bot_nxt     = out_pos_bot_r;
    out_ovf_nxt         = out_ovf_r;
    out_unf_nxt         = out_unf_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_match_found_nxt = 1'b0;
          out_pos_top_nxt     = '0;
          out_pos_bot_nxt     = '0;
          out_ovf_nxt         = 1'b0;
          out_unf_nxt         = 1'b0;
          unique case (op)
            lss_pkg::OP_PUSH: begin
              load = 1'b1;
              if (is_full) begin
                out_ovf_nxt       = 1'b1;
                out_top_value_nxt = cell_val[0];
              end else begin
                count_nxt         = count_r + CW'(1);
                out_top_value_nxt = in_operand_value;
              end
            end
            lss_pkg::OP_POP: begin
              load = 1'b1;
              if (count_r == '0) begin
                out_unf_nxt       = 1'b1;
                out_top_value_nxt = '0;
              end else begin
                count_nxt         = count_r - CW'(1);
                // After a pop the old second entry becomes the top.
                out_top_value_nxt = (count_r > CW'(1)) ? cell_val[1] : '0;
              end
            end
            lss_pkg::OP_CLEAR: begin
              load              = 1'b1;
              count_nxt         = '0;
              out_top_value_nxt = '0;
            end
            lss_pkg::OP_SEARCH: begin
              state_nxt = ST_LAUNCH;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
          out_entry_count_nxt = lss_pkg::COUNT_W'(count_nxt);
          out_is_empty_nxt    = (count_nxt == '0);
        end
      end
      ST_LAUNCH: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (tree_done) begin
          load                = 1'b1;
          state_nxt           = ST_IDLE;
          out_top_value_nxt   = (count_r != '0) ? cell_val[0] : '0;
          out_entry_count_nxt = lss_pkg::COUNT_W'(count_r);
          out_is_empty_nxt    = (count_r == '0);
          out_match_found_nxt = tree_found;
          out_ovf_nxt         = 1'b0;
          out_unf_nxt         = 1'b0;
          // Cell index counts from the top; the bottom entry is count - 1.
          if (tree_found) begin
            out_pos_top_nxt = lss_pkg::POS_W'(tree_lo);
            out_pos_bot_nxt = lss_pkg::POS_W'(count_r - CW'(1) - CW'(tree_hi));
          end else begin
            out_pos_top_nxt = '0;
            out_pos_bot_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload and search key carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_operand_value;
    end
    out_top_value_r   <= out_top_value_nxt;
    out_entry_count_r <= out_entry_count_nxt;
    out_is_empty_r    <= out_is_empty_nxt;
    out_match_found_r <= out_match_found_nxt;
    out_pos_top_r     <= out_pos_top_nxt;
    out_pos_bot_r     <= out_pos_bot_nxt;
    out_ovf_r         <= out_ovf_nxt;
    out_unf_r         <= out_unf_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_top_value       = out_top_value_r;
  assign out_entry_count     = out_entry_count_r;
  assign out_is_empty        = out_is_empty_r;
  assign out_match_found     = out_match_found_r;
  assign out_pos_from_top    = out_pos_top_r;
  assign out_pos_from_bottom = out_pos_bot_r;
  assign out_overflow_flag   = out_ovf_r;
  assign out_underflow_flag  = out_unf_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_count_bound, count_r <= CW'(STACK_DEPTH), "fill count beyond stack depth")
  `ASSERT_IMPLY(a_done_in_wait, tree_done, state_r == ST_WAIT, "tree answer outside search wait")
  `ASSERT_IMPLY(a_load_free, load, !out_valid_r || out_ready, "result register overwritten")
  `ASSERT_NEXT(a_push_top, cell_ctrl.shift_dn, out_top_value == $past(in_operand_value) && out_valid, "pushed word not on top")
  `ASSERT_ALWAYS(a_flags_excl, !(out_valid && out_overflow_flag && out_underflow_flag), "overflow and underflow together")

endmodule

@@ design/lss_cell.sv @@
// ----------------------------------------------------------------------------
// lss_cell
// One stack entry: shifts down on push, up on pop, and compares with the key.
// ----------------------------------------------------------------------------
module lss_cell (
  input  logic                                  clk,
  input  lss_pkg::cell_ctrl_t                   ctrl,
  input  logic signed [lss_pkg::VALUE_W-1:0]    from_above,
  input  logic signed [lss_pkg::VALUE_W-1:0]    from_below,
  input  logic signed [lss_pkg::VALUE_W-1:0]    key,
  output logic signed [lss_pkg::VALUE_W-1:0]    value,
  output logic                                  match
);

  logic signed [lss_pkg::VALUE_W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift_dn) begin
      val_r <= from_above;
    end else if (ctrl.shift_up) begin
      val_r <= from_below;
    end
  end

  assign value = val_r;
  assign match = (val_r == key);

endmodule

@@ design/lss_match_tree.sv @@
// ----------------------------------------------------------------------------
// lss_match_tree
// Registered binary tree that finds the lowest and highest set hit index.
// ----------------------------------------------------------------------------
module lss_match_tree #(
  parameter int N  = 64,
  parameter int IW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [N-1:0]  hits,
  output logic          done,
  output logic          found,
  output logic [IW-1:0] lo,
  output logic [IW-1:0] hi
);

  localparam int P = 2 ** IW;

  // Heap layout: node k has children 2k and 2k+1, leaves sit at P..2P-1.
  logic          node_found_r [1:2*P-1];
  logic [IW-1:0] node_lo_r    [1:2*P-1];
  logic [IW-1:0] node_hi_r    [1:2*P-1];
  logic [IW:0]   vld_r;
  logic [P-1:0]  hits_pad;

  // Leaves past the last entry never hit.
  assign hits_pad = P'(hits);

  for (genvar i = 0; i < P; i++) begin : g_leaf
    always_ff @(posedge clk) begin
      node_found_r[P+i] <= hits_pad[i];
      node_lo_r[P+i]    <= IW'(i);
      node_hi_r[P+i]    <= IW'(i);
    end
  end

  // The left child always covers the lower indexes.
  for (genvar k = 1; k < P; k++) begin : g_node
    always_ff @(posedge clk) begin
      node_found_r[k] <= node_found_r[2*k] | node_found_r[2*k+1];
      node_lo_r[k]    <= node_found_r[2*k]   ? node_lo_r[2*k]   : node_lo_r[2*k+1];
      node_hi_r[k]    <= node_found_r[2*k+1] ? node_hi_r[2*k+1] : node_hi_r[2*k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[IW-1:0], go};
    end
  end

  assign done  = vld_r[IW];
  assign found = node_found_r[1];
  assign lo    = node_lo_r[1];
  assign hi    = node_hi_r[1];

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the searchable LIFO stack lifo_stack_with_search.
// A scoreboard object keeps its own copy of the stack. It predicts the one
// result item that every accepted input item causes and checks each result
// item against the oldest prediction. Plain tasks drive a directed opening
// and then random episodes that fill, drain, mix and search the stack. Both
// channels idle at random, and the result side holds off once for a long
// stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------

// One result item, with the fields in the order of the result ports.
typedef struct packed {
  logic signed [lss_pkg::VALUE_W-1:0] top_value;
  logic [lss_pkg::COUNT_W-1:0]        entry_count;
  logic                               is_empty;
  logic                               match_found;
  logic [lss_pkg::POS_W-1:0]          pos_from_top;
  logic [lss_pkg::POS_W-1:0]          pos_from_bottom;
  logic                               overflow_flag;
  logic                               underflow_flag;
} stack_result_t;

class stack_scoreboard;
  localparam int DEPTH       = 64;
  localparam int PRINT_LIMIT = 40;

  logic [lss_pkg::VALUE_W-1:0] shadow_words [DEPTH];
  int                          shadow_fill;
  stack_result_t               results_due [$];

  int error_count;
  int results_checked;
  int n_push, n_pop, n_clear, n_search;
  int n_overflow, n_underflow, n_hits, peak_fill;

  function new();
    shadow_fill     = 0;
    error_count     = 0;
    results_checked = 0;
    n_push          = 0;
    n_pop           = 0;
    n_clear         = 0;
    n_search        = 0;
    n_overflow      = 0;
    n_underflow     = 0;
    n_hits          = 0;
    peak_fill       = 0;
  endfunction

  // Applies one accepted input item to the shadow stack and queues the
  // result item that the block must answer with.
  function void record_operation(lss_pkg::opcode_t op,
                                 logic [lss_pkg::VALUE_W-1:0] operand);
    stack_result_t r;
    int            i;
    r = '0;
    case (op)
      lss_pkg::OP_PUSH: begin
        n_push++;
        if (shadow_fill >= DEPTH) begin
          r.overflow_flag = 1'b1;
          n_overflow++;
        end else begin
          shadow_words[shadow_fill] = operand;
          shadow_fill++;
        end
      end
      lss_pkg::OP_POP: begin
        n_pop++;
        if (shadow_fill == 0) begin
          r.underflow_flag = 1'b1;
          n_underflow++;
        end else begin
          shadow_fill--;
        end
      end
      lss_pkg::OP_CLEAR: begin
        n_clear++;
        shadow_fill = 0;
      end
      default: begin
        n_search++;
        for (i = 0; i < shadow_fill; i++) begin
          if (shadow_words[i] == operand) begin
            r.match_found     = 1'b1;
            r.pos_from_bottom = i[lss_pkg::POS_W-1:0];
            break;
          end
        end
        if (r.match_found) begin
          n_hits++;
          for (i = shadow_fill - 1; i >= 0; i--) begin
            if (shadow_words[i] == operand) begin
              r.pos_from_top = lss_pkg::POS_W'(shadow_fill - 1 - i);
              break;
            end
          end
        end
      end
    endcase
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    r.top_value   = (shadow_fill > 0) ? shadow_words[shadow_fill - 1] : '0;
    r.entry_count = lss_pkg::COUNT_W'(shadow_fill);
    r.is_empty    = (shadow_fill == 0);
    results_due.push_back(r);
  endfunction

  task report_mismatch(string what, logic [lss_pkg::VALUE_W-1:0] got,
                       logic [lss_pkg::VALUE_W-1:0] want);
    if (error_count < PRINT_LIMIT)
      $display("[%0t] mismatch on result %0d: %s got %h, expected %h",
               $time, results_checked, what, got, want);
    error_count++;
  endtask

  // Compares one accepted result item with the oldest prediction.
  task check_response(stack_result_t seen);
    stack_result_t want;
    if (results_due.size() == 0) begin
      report_mismatch("unexpected result item", seen.top_value, '0);
    end else begin
      want = results_due.pop_front();
      if (seen.top_value !== want.top_value)
        report_mismatch("top_value", seen.top_value, want.top_value);
      if (seen.entry_count !== want.entry_count)
        report_mismatch("entry_count", seen.entry_count, want.entry_count);
      if (seen.is_empty !== want.is_empty)
        report_mismatch("is_empty", seen.is_empty, want.is_empty);
      if (seen.match_found !== want.match_found)
        report_mismatch("match_found", seen.match_found, want.match_found);
      if (seen.pos_from_top !== want.pos_from_top)
        report_mismatch("pos_from_top", seen.pos_from_top, want.pos_from_top);
      if (seen.pos_from_bottom !== want.pos_from_bottom)
        report_mismatch("pos_from_bottom", seen.pos_from_bottom, want.pos_from_bottom);
      if (seen.overflow_flag !== want.overflow_flag)
        report_mismatch("overflow_flag", seen.overflow_flag, want.overflow_flag);
      if (seen.underflow_flag !== want.underflow_flag)
        report_mismatch("underflow_flag", seen.underflow_flag, want.underflow_flag);
    end
    results_checked++;
  endtask

  function int outstanding();
    return results_due.size();
  endfunction
endclass

module testbench;

  localparam int STACK_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 900;
  // Cycles the result side refuses items during the pressure episode.
  localparam int HOLD_CYCLES  = 300;
  // The tail wait after the last result scales with the depth of the search
  // tree and leaves margin.
  localparam int TAIL_CYCLES  = 3 * ($clog2(STACK_DEPTH) + 3);
  // Slowest legal item: the longest sender gap, a search and the longest
  // receiver stall, far below the long hold-off. The limit is several times
  // that hold-off.
  localparam int QUIET_LIMIT  = 4 * HOLD_CYCLES;

  logic                               clk              = 1'b0;
  logic                               rst_n            = 1'b0;
  logic                               in_valid         = 1'b0;
  logic                               in_ready;
  logic [1:0]                         in_opcode        = '0;
  logic signed [lss_pkg::VALUE_W-1:0] in_operand_value = '0;
  logic                               out_valid;
  logic                               out_ready        = 1'b0;
  logic signed [lss_pkg::VALUE_W-1:0] out_top_value;
  logic [lss_pkg::COUNT_W-1:0]        out_entry_count;
  logic                               out_is_empty;
  logic                               out_match_found;
  logic [lss_pkg::POS_W-1:0]          out_pos_from_top;
  logic [lss_pkg::POS_W-1:0]          out_pos_from_bottom;
  logic                               out_overflow_flag;
  logic                               out_underflow_flag;

  stack_scoreboard sb = new();

  // Stimulus-side bookkeeping. The depth seen by the generator lets the
  // episodes aim at full and empty stacks; the recent pushes give searches
  // a good chance of a hit.
  int                          gen_level        = 0;
  logic [lss_pkg::VALUE_W-1:0] recent_pushes [$];
  int                          items_sent       = 0;
  bit                          gaps_off         = 1'b0;
  int                          send_calm_left   = 0;
  int                          take_calm_left   = 0;
  bit                          hold_off_req     = 1'b0;
  stack_result_t               observed;

  always #5 clk = ~clk;

  lifo_stack_with_search #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_operand_value    (in_operand_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_top_value       (out_top_value),
    .out_entry_count     (out_entry_count),
    .out_is_empty        (out_is_empty),
    .out_match_found     (out_match_found),
    .out_pos_from_top    (out_pos_from_top),
    .out_pos_from_bottom (out_pos_from_bottom),
    .out_overflow_flag   (out_overflow_flag),
    .out_underflow_flag  (out_underflow_flag)
  );

  // Monitor. It samples at the rising edge, before any nonblocking update
  // of that edge lands, so it sees exactly what the block saw. An input
  // item is recorded before a result item of the same edge is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.record_operation(lss_pkg::opcode_t'(in_opcode), in_operand_value);
      if (out_valid && out_ready) begin
        observed.top_value       = out_top_value;
        observed.entry_count     = out_entry_count;
        observed.is_empty        = out_is_empty;
        observed.match_found     = out_match_found;
        observed.pos_from_top    = out_pos_from_top;
        observed.pos_from_bottom = out_pos_from_bottom;
        observed.overflow_flag   = out_overflow_flag;
        observed.underflow_flag  = out_underflow_flag;
        sb.check_response(observed);
      end
    end
  end

  // Watchdog. Any run of cycles without a handshake on either channel
  // that reaches the limit means the block has hung.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog: no item moved for %0d cycles", QUIET_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Sender idle time per item. Calm stretches with no gaps come now and
  // then, and the pressure episode turns gaps off altogether.
  function automatic int sender_gap();
    if (gaps_off) return 0;
    if (send_calm_left > 0) begin
      send_calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      send_calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [lss_pkg::VALUE_W-1:0] extreme_value();
    case ($urandom_range(0, 4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // Operand mix: extremes, a small pool that produces duplicates, and full
  // random words. Searches lean on values pushed recently.
  function automatic logic [lss_pkg::VALUE_W-1:0] pick_value(bit for_search);
    int sel;
    sel = $urandom_range(0, 9);
    if (for_search && recent_pushes.size() > 0 && sel < 5)
      return recent_pushes[$urandom_range(0, recent_pushes.size() - 1)];
    if (sel == 0) return extreme_value();
    if (sel < 4) return lss_pkg::VALUE_W'($signed($urandom_range(0, 11)) - 4);
    return $urandom;
  endfunction

  function automatic lss_pkg::opcode_t pick_op(int push_pct, int pop_pct, int clear_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return lss_pkg::OP_PUSH;
    if (roll < push_pct + pop_pct) return lss_pkg::OP_POP;
    if (roll < push_pct + pop_pct + clear_pct) return lss_pkg::OP_CLEAR;
    return lss_pkg::OP_SEARCH;
  endfunction

  // Offers one input item and returns at the edge where it is accepted.
  // While idle the payload carries junk so that the block must honor valid.
  task automatic send_item(input lss_pkg::opcode_t op,
                           input logic [lss_pkg::VALUE_W-1:0] value);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid         <= 1'b0;
      in_opcode        <= 2'($urandom_range(0, 3));
      in_operand_value <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_operand_value <= value;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    case (op)
      lss_pkg::OP_PUSH: begin
        if (gen_level < STACK_DEPTH) gen_level++;
        recent_pushes.push_back(value);
        if (recent_pushes.size() > 16) void'(recent_pushes.pop_front());
      end
      lss_pkg::OP_POP:   if (gen_level > 0) gen_level--;
      lss_pkg::OP_CLEAR: gen_level = 0;
      default:  ;
    endcase
  endtask

  task automatic send_random(input lss_pkg::opcode_t op);
    send_item(op, pick_value(op == lss_pkg::OP_SEARCH));
  endtask

  // Pushes until the stack is full, with a few searches mixed in, searches
  // once more, then pushes a few more that must be refused.
  task automatic fill_episode();
    int extra;
    extra = $urandom_range(1, 3);
    while (gen_level < STACK_DEPTH) begin
      if ($urandom_range(0, 9) == 0) send_random(lss_pkg::OP_SEARCH);
      else send_random(lss_pkg::OP_PUSH);
    end
    send_random(lss_pkg::OP_SEARCH);
    repeat (extra) send_random(lss_pkg::OP_PUSH);
  endtask

  // Pops down to empty, with a few searches mixed in, then pops a few more that must underflow.
  task automatic drain_episode();
    int extra;
    extra = $urandom_range(1, 3);
    while (gen_level > 0) begin
      if ($urandom_range(0, 7) == 0) send_random(lss_pkg::OP_SEARCH);
      else send_random(lss_pkg::OP_POP);
    end
    repeat (extra) send_random(lss_pkg::OP_POP);
  endtask

  task automatic mixed_episode(input int count, input int push_pct, input int pop_pct,
                               input int clear_pct);
    repeat (count) send_random(pick_op(push_pct, pop_pct, clear_pct));
  endtask

  // Directed opening: operations on an empty stack, the value extremes,
  // duplicates with distinct top and bottom matches, a miss, and the rule
  // that words left behind by a clear are never found again.
  task automatic run_directed();
    send_item(lss_pkg::OP_POP,    32'h0);
    send_item(lss_pkg::OP_SEARCH, 32'h0);
    send_item(lss_pkg::OP_CLEAR,  32'hFFFF_FFFF);
    send_item(lss_pkg::OP_PUSH,   32'h8000_0000);
    send_item(lss_pkg::OP_PUSH,   32'h7FFF_FFFF);
    send_item(lss_pkg::OP_PUSH,   32'h0000_0000);
    send_item(lss_pkg::OP_PUSH,   32'hFFFF_FFFF);
    send_item(lss_pkg::OP_PUSH,   32'h7FFF_FFFF);
    send_item(lss_pkg::OP_SEARCH, 32'h7FFF_FFFF);
    send_item(lss_pkg::OP_SEARCH, 32'h8000_0000);
    send_item(lss_pkg::OP_SEARCH, 32'd12345);
    send_item(lss_pkg::OP_SEARCH, 32'hFFFF_FFFF);
    send_item(lss_pkg::OP_POP,    32'h5A5A_5A5A);
    send_item(lss_pkg::OP_SEARCH, 32'h7FFF_FFFF);
    send_item(lss_pkg::OP_POP,    32'h0);
    send_item(lss_pkg::OP_POP,    32'h0);
    send_item(lss_pkg::OP_PUSH,   32'h5555_5555);
    send_item(lss_pkg::OP_PUSH,   32'hAAAA_AAAA);
    send_item(lss_pkg::OP_CLEAR,  32'h0);
    send_item(lss_pkg::OP_SEARCH, 32'h5555_5555);
    send_item(lss_pkg::OP_POP,    32'h0);
    send_item(lss_pkg::OP_PUSH,   32'd5);
    send_item(lss_pkg::OP_SEARCH, 32'd5);
    send_item(lss_pkg::OP_CLEAR,  32'h0);
  endtask

  // Result side. Each result item is preceded by a random stall, with calm
  // stretches of none. A hold-off request turns the next stall into a long
  // one, during which the sender keeps offering items.
  initial begin : result_taker
    int stall;
    repeat (5) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        stall = HOLD_CYCLES;
      end else if (take_calm_left > 0) begin
        take_calm_left--;
        stall = 0;
      end else if ($urandom_range(0, 19) == 0) begin
        take_calm_left = $urandom_range(10, 40);
        stall = 0;
      end else begin
        stall = $urandom_range(0, 13);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Main sequence: reset, directed items, random episodes, drain, verdict.
  initial begin : stimulus
    int start_count;
    int kind;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    // The first random episode is the pressure test: the result side holds
    // off while a gap-free run of pushes backs the block up.
    start_count  = items_sent;
    hold_off_req = 1'b1;
    gaps_off     = 1'b1;
    fill_episode();
    gaps_off     = 1'b0;

    while (items_sent - start_count < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1:    fill_episode();
        2, 3:    drain_episode();
        4, 5, 6: mixed_episode($urandom_range(20, 60), 40, 30, 5);
        7, 8:    mixed_episode($urandom_range(20, 40), 25, 10, 0);
        default: mixed_episode($urandom_range(5, 20), 20, 20, 30);
      endcase
    end
    in_valid <= 1'b0;

    // Wait for every predicted result, then wait out the tail to catch any
    // result item the block should never have produced.
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    // Any prediction still queued here is a result item that never came.
    if (sb.outstanding() > 0)
      sb.report_mismatch("result items never delivered",
                         lss_pkg::VALUE_W'(sb.outstanding()), '0);

    $display("Run covered %0d items: %0d push, %0d pop, %0d clear, %0d search.",
             items_sent, sb.n_push, sb.n_pop, sb.n_clear, sb.n_search);
    $display("It saw %0d overflows, %0d underflows, %0d search hits, peak depth %0d.",
             sb.n_overflow, sb.n_underflow, sb.n_hits, sb.peak_fill);
    if (sb.error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches found", sb.error_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
